/* hdl/lap3_pkg.sv */
// Shared types, constants and helpers for the 3x3 Laplacian sharpening block.
// No dependencies.
`default_nettype none

package lap3_pkg;

    // pixel and channel layout
    localparam int PIX_W    = 8;
    localparam int CHANNELS = 3;
    localparam int RGB_W    = PIX_W * CHANNELS;
    // sum of nine channel values, also holds 9*center
    localparam int SUM_W    = 12;
    localparam logic [PIX_W-1:0] PIX_MAX = 8'hFF;

    // configuration register layout
    localparam int WIDTH_W   = 11;
    localparam int HEIGHT_W  = 13;
    localparam int CFG_DATA_W = 13;
    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    // reset values and defaults
    localparam int RESET_WIDTH    = 640;
    localparam int RESET_HEIGHT   = 480;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;
    localparam int MIN_DIM        = 3;

    // per-pixel position tags carried down the pipeline
    typedef struct packed {
        logic interior;
        logic row_end;
        logic frame_end;
    } pix_tag_t;

    // clamp a frame dimension to [MIN_DIM, hi]
    function automatic logic [31:0] clamp_dim(logic [31:0] v, logic [31:0] hi);
        logic [31:0] r;
        r = v;
        if (v < 32'(MIN_DIM)) begin
            r = 32'(MIN_DIM);
        end else if (v > hi) begin
            r = hi;
        end
        return r;
    endfunction

    // channel k of a packed pixel, red in the lowest byte
    function automatic logic [PIX_W-1:0] chan(logic [RGB_W-1:0] px, int k);
        return px[PIX_W*k +: PIX_W];
    endfunction

endpackage

`default_nettype wire

/* hdl/laplacian_sharpen_3x3.sv */
// Top level of the 3x3 Laplacian sharpening filter for raster-order RGB streams.
// Depends on lap3_pkg.
`default_nettype none

// Takes one RGB pixel per clock in raster order, while the output is not stalled,
// and returns one sharpened pixel per interior pixel of the frame (borders
// produce nothing), so output runs at one pixel per clock with gaps on border
// columns and the first two rows. A result passes through stage 1, stage 2 and
// the output register after the pixel below-right of its center is transferred
// in. The two previous rows sit in one line memory with one write and one read
// port per cycle; the read is issued when a pixel is taken in and the row is
// shifted back at the same column one stage later, which is what allows a new
// pixel every cycle unless the output stalls. tlast marks the last result of a row,
// tuser the last result of the frame. Frame width and height are written through
// the configuration port while the stream is idle; any valid write restarts the
// frame at its first pixel. Line memory contents need no clearing after reset.
module laplacian_sharpen_3x3 #(
    parameter int MAX_WIDTH  = lap3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = lap3_pkg::DEF_MAX_HEIGHT
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // configuration write port
    input  wire logic                               cfg_wr_en,
    input  wire logic [lap3_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lap3_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    // pixel input
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [lap3_pkg::RGB_W-1:0]         s_axis_tdata,  // red_in, green_in, blue_in
    // sharpened output
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [lap3_pkg::RGB_W-1:0]              m_axis_tdata,  // red_out, green_out, blue_out
    output logic                                    m_axis_tlast,  // row_end
    output logic                                    m_axis_tuser   // frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = lap3_pkg::PIX_W;
    localparam int NC = lap3_pkg::CHANNELS;
    localparam int XW = lap3_pkg::RGB_W;
    localparam int SW = lap3_pkg::SUM_W;
    localparam logic [31:0] MAX_W32 = 32'(MAX_WIDTH);
    localparam logic [31:0] MAX_H32 = 32'(MAX_HEIGHT);

    // frame geometry, stored as last column / last row
    logic [CW-1:0] w_last_reg;
    logic [RW-1:0] h_last_reg;
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    // stage 1: pixel waiting for its line memory read
    logic               s1_valid_reg;
    logic [XW-1:0]      s1_pix_reg;
    logic [CW-1:0]      s1_col_reg;
    lap3_pkg::pix_tag_t s1_tag_reg;

    // line memory: {upper row, middle row} per column
    logic [2*XW-1:0] line_mem [MAX_WIDTH];
    logic [2*XW-1:0] rd_data_reg;

    // window: two previous columns of the 3-row neighborhood
    logic [XW-1:0] win_reg [6];

    // stage 2: sums and centers
    logic               s2_valid_reg;
    logic [SW-1:0]      s2_sum_reg    [NC];
    logic [PW-1:0]      s2_center_reg [NC];
    lap3_pkg::pix_tag_t s2_tag_reg;

    // output register
    logic          m_valid_reg;
    logic [XW-1:0] m_data_reg;
    logic          m_last_reg;
    logic          m_user_reg;

    // handshake chain
    logic out_ready, s2_ready, s1_fire, s_accept;
    logic [XW-1:0] top_px, mid_px;
    lap3_pkg::pix_tag_t in_tag;
    logic [SW-1:0] sum_next [NC];
    logic [XW-1:0] res_next;

    assign out_ready     = !m_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_fire       = s1_valid_reg && s2_ready;
    assign s_axis_tready = !s1_valid_reg || s2_ready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tuser  = m_user_reg;

    // position of the incoming pixel
    always_comb begin
        in_tag.interior  = (col_reg >= CW'(2)) && (row_reg >= RW'(2));
        in_tag.row_end   = (col_reg == w_last_reg);
        in_tag.frame_end = (col_reg == w_last_reg) && (row_reg == h_last_reg);
        col_next = col_reg;
        row_next = row_reg;
        if (col_reg == w_last_reg) begin
            col_next = '0;
            row_next = (row_reg == h_last_reg) ? '0 : row_reg + RW'(1);
        end else begin
            col_next = col_reg + CW'(1);
        end
    end

    // geometry registers and raster counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w_last_reg <= CW'(lap3_pkg::clamp_dim(32'(lap3_pkg::RESET_WIDTH), MAX_W32) - 32'd1);
            h_last_reg <= RW'(lap3_pkg::clamp_dim(32'(lap3_pkg::RESET_HEIGHT), MAX_H32) - 32'd1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en && cfg_index == lap3_pkg::REG_FRAME_WIDTH) begin
            w_last_reg <= CW'(lap3_pkg::clamp_dim(
                32'(cfg_wdata[lap3_pkg::WIDTH_W-1:0]), MAX_W32) - 32'd1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (cfg_wr_en && cfg_index == lap3_pkg::REG_FRAME_HEIGHT) begin
            h_last_reg <= RW'(lap3_pkg::clamp_dim(
                32'(cfg_wdata[lap3_pkg::HEIGHT_W-1:0]), MAX_H32) - 32'd1);
            col_reg    <= '0;
            row_reg    <= '0;
        end else if (s_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // line memory: read on transfer in, write back when stage 1 moves on
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rd_data_reg <= line_mem[col_reg];
        end
        if (s1_fire) begin
            line_mem[s1_col_reg] <= {rd_data_reg[XW-1:0], s1_pix_reg};
        end
    end

    // stage 1 control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            s1_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_pix_reg <= s_axis_tdata;
            s1_col_reg <= col_reg;
            s1_tag_reg <= in_tag;
        end
    end

    assign top_px = rd_data_reg[2*XW-1:XW];
    assign mid_px = rd_data_reg[XW-1:0];

    // nine-point sum per channel
    always_comb begin
        for (int k = 0; k < NC; k++) begin
            sum_next[k] = SW'(lap3_pkg::chan(win_reg[0], k))
                        + SW'(lap3_pkg::chan(win_reg[1], k))
                        + SW'(lap3_pkg::chan(win_reg[2], k))
                        + SW'(lap3_pkg::chan(win_reg[3], k))
                        + SW'(lap3_pkg::chan(win_reg[4], k))
                        + SW'(lap3_pkg::chan(win_reg[5], k))
                        + SW'(lap3_pkg::chan(top_px, k))
                        + SW'(lap3_pkg::chan(mid_px, k))
                        + SW'(lap3_pkg::chan(s1_pix_reg, k));
        end
    end

    // window shift and stage 2 payload
    always_ff @(posedge aclk) begin
        if (s1_fire) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_px;
            win_reg[4] <= mid_px;
            win_reg[5] <= s1_pix_reg;
            for (int k = 0; k < NC; k++) begin
                s2_sum_reg[k]    <= sum_next[k];
                s2_center_reg[k] <= lap3_pkg::chan(win_reg[4], k);
            end
            s2_tag_reg <= s1_tag_reg;
        end
    end

    // stage 2 control: only interior pixels go on
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (s2_ready) begin
            s2_valid_reg <= s1_fire && s1_tag_reg.interior;
        end
    end

    // delta = 9*center - sum, floored at zero; result saturated
    always_comb begin
        logic [SW-1:0] pos;
        logic [SW-1:0] delta;
        logic [SW:0]   res;
        for (int k = 0; k < NC; k++) begin
            pos   = SW'({s2_center_reg[k], 3'b000}) + SW'(s2_center_reg[k]);
            delta = (pos > s2_sum_reg[k]) ? pos - s2_sum_reg[k] : '0;
            res   = {1'b0, delta} + (SW+1)'(s2_center_reg[k]);
            res_next[PW*k +: PW] = (res > (SW+1)'(lap3_pkg::PIX_MAX)) ?
                                   lap3_pkg::PIX_MAX : res[PW-1:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_ready) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready && s2_valid_reg) begin
            m_data_reg <= res_next;
            m_last_reg <= s2_tag_reg.row_end;
            m_user_reg <= s2_tag_reg.frame_end;
        end
    end

`ifndef SYNTHESIS
    // the frame end always falls on a row end
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_user_reg |-> m_last_reg)
        else $error("frame end without row end");

    // raster counter stays inside the configured frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg <= w_last_reg && row_reg <= h_last_reg)
        else $error("raster counter beyond frame geometry");

    // an interior pixel leaving stage 1 lands in stage 2
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_fire && s1_tag_reg.interior |=> s2_valid_reg)
        else $error("interior pixel lost between stages");
`endif

endmodule

`default_nettype wire

/* tb/sharpen_checker.sv */
// Checker for the 3x3 Laplacian sharpening block: watches the config port and both
// stream channels, predicts every sharpened pixel and compares it field by field.
// Depends on lap3_pkg.
`timescale 1ns / 100ps

module sharpen_checker
    import lap3_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_axis_tvalid,
    input  wire logic                  s_axis_tready,
    input  wire logic [RGB_W-1:0]      s_axis_tdata,   // red_in, green_in, blue_in
    input  wire logic                  m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    input  wire logic [RGB_W-1:0]      m_axis_tdata,   // red_out, green_out, blue_out
    input  wire logic                  m_axis_tlast,   // row_end
    input  wire logic                  m_axis_tuser,   // frame_end
    output int unsigned                mismatch_count,
    output int unsigned                results_pending,
    output int unsigned                results_checked
);

    // red sits in the lowest byte of tdata
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        rgb_t px;
        logic row_end;
        logic frame_end;
    } sharp_pix_t;

    // predicted block state
    rgb_t                upper_row  [DEF_MAX_WIDTH];
    rgb_t                middle_row [DEF_MAX_WIDTH];
    rgb_t                window     [6];
    int unsigned         col_pos;
    int unsigned         row_pos;
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;

    sharp_pix_t  sharpened_queue[$];
    int unsigned errs = 0;
    int unsigned checked = 0;

    initial begin
        for (int i = 0; i < DEF_MAX_WIDTH; i++) begin
            upper_row[i]  = '0;
            middle_row[i] = '0;
        end
    end

    // out-of-range dimensions snap to the nearest legal size
    function automatic int unsigned clip_dim(int unsigned v, int unsigned hi);
        if (v < MIN_DIM) return MIN_DIM;
        if (v > hi) return hi;
        return v;
    endfunction

    // one channel: center plus (8*center - neighbours), floor 0, saturate at 255
    function automatic logic [PIX_W-1:0] sharpen(logic [8:0][PIX_W-1:0] ch);
        int unsigned total;
        int unsigned nine_c;
        int unsigned boost;
        int unsigned res;
        total = 0;
        for (int i = 0; i < 9; i++) total += ch[i];
        nine_c = 9 * ch[4];
        boost  = (nine_c > total) ? nine_c - total : 0;
        res    = ch[4] + boost;
        return (res > PIX_MAX) ? PIX_MAX : res[PIX_W-1:0];
    endfunction

    // advance the predicted pipeline by one accepted pixel
    task automatic take_pixel(input rgb_t px);
        int unsigned w;
        int unsigned h;
        int unsigned c;
        int unsigned r;
        rgb_t above;
        rgb_t middle;
        rgb_t nb [9];
        logic [8:0][PIX_W-1:0] rs;
        logic [8:0][PIX_W-1:0] gs;
        logic [8:0][PIX_W-1:0] bs;
        sharp_pix_t res;
        w = clip_dim(width_reg, DEF_MAX_WIDTH);
        h = clip_dim(height_reg, DEF_MAX_HEIGHT);
        c = (col_pos >= w) ? 0 : col_pos;
        r = (row_pos >= h) ? 0 : row_pos;

        above         = upper_row[c];
        middle        = middle_row[c];
        upper_row[c]  = middle;
        middle_row[c] = px;

        // interior center sits one up and one left of this pixel
        if (c >= 2 && r >= 2) begin
            for (int i = 0; i < 6; i++) nb[i] = window[i];
            nb[6] = above;
            nb[7] = middle;
            nb[8] = px;
            for (int i = 0; i < 9; i++) begin
                rs[i] = nb[i].red;
                gs[i] = nb[i].green;
                bs[i] = nb[i].blue;
            end
            res.px.red    = sharpen(rs);
            res.px.green  = sharpen(gs);
            res.px.blue   = sharpen(bs);
            res.row_end   = (c == w - 1);
            res.frame_end = (c == w - 1) && (r == h - 1);
            sharpened_queue.push_back(res);
        end

        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = above;
        window[4] = middle;
        window[5] = px;

        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    // compare one output transfer with the oldest prediction
    task automatic check_result();
        sharp_pix_t want;
        rgb_t got;
        got = rgb_t'(m_axis_tdata);
        if (sharpened_queue.size() == 0) begin
            $error("sharpened pixel with none expected: tdata %h", m_axis_tdata);
            errs++;
        end else begin
            want = sharpened_queue.pop_front();
            checked++;
            if (got.red !== want.px.red) begin
                $error("red_out: expected %0d, got %0d", want.px.red, got.red);
                errs++;
            end
            if (got.green !== want.px.green) begin
                $error("green_out: expected %0d, got %0d", want.px.green, got.green);
                errs++;
            end
            if (got.blue !== want.px.blue) begin
                $error("blue_out: expected %0d, got %0d", want.px.blue, got.blue);
                errs++;
            end
            if (m_axis_tlast !== want.row_end) begin
                $error("row_end: expected %0d, got %0d", want.row_end, m_axis_tlast);
                errs++;
            end
            if (m_axis_tuser !== want.frame_end) begin
                $error("frame_end: expected %0d, got %0d", want.frame_end, m_axis_tuser);
                errs++;
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) window[i] = '0;
            col_pos    = 0;
            row_pos    = 0;
            width_reg  = WIDTH_W'(RESET_WIDTH);
            height_reg = HEIGHT_W'(RESET_HEIGHT);
            sharpened_queue.delete();
        end else begin
            // a valid register write restarts the frame; others are dropped
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_FRAME_WIDTH: begin
                        width_reg = cfg_wdata[WIDTH_W-1:0];
                        col_pos   = 0;
                        row_pos   = 0;
                    end
                    REG_FRAME_HEIGHT: begin
                        height_reg = cfg_wdata[HEIGHT_W-1:0];
                        col_pos    = 0;
                        row_pos    = 0;
                    end
                    default: ;
                endcase
            end
            // output first: a pixel never leaves on the edge its source enters
            if (m_axis_tvalid && m_axis_tready) check_result();
            if (s_axis_tvalid && s_axis_tready) take_pixel(rgb_t'(s_axis_tdata));
        end
        mismatch_count  <= errs;
        results_pending <= sharpened_queue.size();
        results_checked <= checked;
    end

endmodule

/* tb/testbench.sv */
// Top of the sharpening testbench: clock, reset, pixel stimulus, config writes and
// output backpressure; the verdict comes from sharpen_checker.
// Depends on lap3_pkg, laplacian_sharpen_3x3 and sharpen_checker.
`timescale 1ns / 100ps

module testbench;
    import lap3_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 4000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 220;

    // unused register slots, writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {PIX_UNIFORM, PIX_EXTREME, PIX_SMOOTH} pix_style_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [RGB_W-1:0]      s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [RGB_W-1:0]      m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  m_axis_tuser;

    int unsigned mismatch_count;
    int unsigned results_pending;
    int unsigned results_checked;

    int unsigned idle_pct      = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_requests = 0;
    int unsigned holds_started = 0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;
    int unsigned pixels_sent   = 0;
    int unsigned settings_used = 0;

    always #5 aclk = ~aclk;

    laplacian_sharpen_3x3 u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    sharpen_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tlast    (m_axis_tlast),
        .m_axis_tuser    (m_axis_tuser),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending),
        .results_checked (results_checked)
    );

    // output backpressure: random stalls, plus long holds on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (holds_started != hold_requests) begin
            m_axis_tready <= 1'b0;
            holds_started <= holds_started + 1;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [RGB_W-1:0] rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {b, g, r};
    endfunction

    function automatic logic [RGB_W-1:0] random_pixel(pix_style_t style, logic [7:0] base);
        logic [RGB_W-1:0] px;
        int v;
        px = '0;
        for (int k = 0; k < CHANNELS; k++) begin
            case (style)
                PIX_EXTREME: v = $urandom_range(1) ? 255 : 0;
                PIX_SMOOTH: begin
                    // small spread around one base value per call
                    v = int'(base) + int'($urandom_range(12)) - 6;
                    if (v < 0) v = 0;
                    if (v > 255) v = 255;
                end
                default: v = int'($urandom_range(255));
            endcase
            px[PIX_W*k +: PIX_W] = v[7:0];
        end
        return px;
    endfunction

    task automatic set_idle(input idle_mode_t mode);
        case (mode)
            IDLE_SENDER:   begin idle_pct = 85; stall_pct = 0;  end
            IDLE_RECEIVER: begin idle_pct = 0;  stall_pct = 85; end
            IDLE_BOTH:     begin idle_pct = 29; stall_pct = 29; end
            default:       begin idle_pct = 0;  stall_pct = 0;  end
        endcase
    endtask

    // one pixel transfer, with a random gap in front
    task automatic send_pixel(input logic [RGB_W-1:0] px);
        while ($urandom_range(99) < idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= px;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        pixels_sent++;
    endtask

    task automatic send_pixels(input int unsigned count, input pix_style_t style);
        logic [7:0] base;
        base = 8'($urandom_range(255));
        repeat (count) send_pixel(random_pixel(style, base));
    endtask

    // 3x3 frame: one center value inside a uniform ring
    task automatic send_cross(input logic [RGB_W-1:0] center, input logic [RGB_W-1:0] ring);
        for (int i = 0; i < 9; i++) send_pixel((i == 4) ? center : ring);
    endtask

    // drain all predicted results, then let in-flight border pixels clear
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
        settle();
        write_reg(REG_FRAME_WIDTH, w);
        write_reg(REG_FRAME_HEIGHT, h);
        settings_used++;
    endtask

    initial begin
        int unsigned ew;
        int unsigned eh;
        int unsigned n;
        int unsigned k;
        int unsigned sel;
        int unsigned round;
        int unsigned random_sent;
        logic [CFG_DATA_W-1:0] wv;
        logic [CFG_DATA_W-1:0] hv;
        pix_style_t style;

        ew = 64;
        eh = 5;
        round = 0;
        random_sent = 0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset dimensions (640 wide), spare-index writes mid-frame must not restart it
        set_idle(IDLE_NONE);
        settings_used++;
        send_pixels(50, PIX_UNIFORM);
        settle();
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom_range(8191)));
        write_reg(REG_SPARE_3, 13'h1FFF);
        set_idle(IDLE_BOTH);
        send_pixels(50, PIX_SMOOTH);

        // smallest frame, both sizes below the minimum; width upper bits are ignored
        set_frame(13'h1800, 13'h0000);
        set_idle(IDLE_NONE);
        send_cross(rgb(8'd255, 8'd0, 8'd100), rgb(8'd0, 8'd255, 8'd98));
        send_cross(rgb(8'd0, 8'd255, 8'd20), rgb(8'd255, 8'd255, 8'd18));
        send_cross(rgb(8'd255, 8'd255, 8'd0), rgb(8'd255, 8'd0, 8'd0));

        // long output hold while pixels keep coming: input side must stall
        set_frame(13'd16, 13'd4);
        ew = 16;
        eh = 4;
        hold_requests++;
        send_pixels(64, PIX_UNIFORM);

        // random small frames, mostly whole, some cut short by the next write
        while (random_sent < RANDOM_ITEMS) begin
            settle();
            set_idle(idle_mode_t'(round % 4));
            sel = (round == 0) ? 2 : $urandom_range(3);
            if (sel != 1) begin
                ew = $urandom_range(3, 12);
                wv = (ew == 3 && $urandom_range(1)) ? CFG_DATA_W'($urandom_range(2))
                                                    : CFG_DATA_W'(ew);
                wv[12:11] = 2'($urandom_range(3));
                write_reg(REG_FRAME_WIDTH, wv);
            end
            if (sel != 0) begin
                eh = $urandom_range(3, 8);
                hv = (eh == 3 && $urandom_range(1)) ? CFG_DATA_W'($urandom_range(2))
                                                    : CFG_DATA_W'(eh);
                write_reg(REG_FRAME_HEIGHT, hv);
            end
            settings_used++;
            style = pix_style_t'($urandom_range(2));
            if ($urandom_range(7) == 0) n = $urandom_range(1, ew * eh - 1);
            else n = $urandom_range(1, 3) * ew * eh;
            if (n > 1 && $urandom_range(5) == 0) begin
                k = $urandom_range(1, n - 1);
                send_pixels(k, style);
                settle();
                write_reg($urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3,
                          CFG_DATA_W'($urandom_range(8191)));
                send_pixels(n - k, style);
            end else begin
                send_pixels(n, style);
            end
            random_sent += n;
            round++;
        end

        // widest frame: all width bits set clamps to the maximum; first row only
        set_frame(13'h1FFF, 13'd3);
        set_idle(IDLE_BOTH);
        send_pixels(60, PIX_UNIFORM);

        // tallest frame, narrowest width; the first rows only
        set_frame(13'd3, 13'h1FFF);
        set_idle(IDLE_NONE);
        send_pixels(3 * 40, PIX_SMOOTH);

        settle();
        $display("run: %0d pixels over %0d frame settings, %0d sharpened pixels checked",
                 pixels_sent, settings_used, results_checked);
        $display("run: four idle modes, a long output hold, size clamps and spare writes");
        if (mismatch_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
